/* rtl/rmj_pkg.sv */
// Shared constants for the radar measurement Jacobian block.
`timescale 1ns / 1ps
package rmj_pkg;

  // Guard register (Q8.32 squared range threshold).
  localparam int GUARD_WIDTH = 40;
  localparam logic [GUARD_WIDTH-1:0] GUARD_RESET = 40'd429497;

endpackage

/* rtl/rmj_delay.sv */
// Enable-gated delay line carrying a valid bit and a payload.
`timescale 1ns / 1ps
module rmj_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);
  import rmj_pkg::*;

  logic             vld  [0:DEPTH-1];
  logic [WIDTH-1:0] data [0:DEPTH-1];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          data[k] <= in_data;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= vld[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          data[k] <= data[k-1];
        end
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = data[DEPTH-1];

endmodule

/* rtl/rmj_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
`timescale 1ns / 1ps
module rmj_isqrt #(
  parameter int RW  = 32,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] s,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SBW-1:0]  out_sb
);
  import rmj_pkg::*;

  localparam int SW = 2 * RW;

  logic            vld   [0:RW-1];
  logic [RW:0]     rem   [0:RW-1];
  logic [RW-1:0]   rt    [0:RW-1];
  logic [SW-1:0]   srest [0:RW-1];
  logic [SBW-1:0]  sb    [0:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic            v_i;
    logic [RW:0]     rem_i;
    logic [RW-1:0]   rt_i;
    logic [SW-1:0]   s_i;
    logic [SBW-1:0]  sb_i;
    logic [RW+2:0]   cat;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (k == 0) begin : g_in
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign rt_i  = '0;
      assign s_i   = s;
      assign sb_i  = in_sb;
    end else begin : g_mid
      assign v_i   = vld[k-1];
      assign rem_i = rem[k-1];
      assign rt_i  = rt[k-1];
      assign s_i   = srest[k-1];
      assign sb_i  = sb[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign cat   = {rem_i, s_i[SW-1 -: 2]};
    assign trial = {1'b0, rt_i, 2'b01};
    assign diff  = cat - trial;
    assign ge    = cat >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    // remainder stays within twice the partial root, so RW+1 bits hold it
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? diff[RW:0] : cat[RW:0];
        rt[k]    <= {rt_i[RW-2:0], ge};
        srest[k] <= {s_i[SW-3:0], 2'b00};
        sb[k]    <= sb_i;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt[RW-1];
  assign out_sb    = sb[RW-1];

endmodule

/* rtl/rmj_div.sv */
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
`timescale 1ns / 1ps
module rmj_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);
  import rmj_pkg::*;

  localparam int TW = NW - QW;
  localparam int MW = (TW > DW) ? TW : DW;

  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] low [0:QW];
  logic [QW-1:0] q   [0:QW];
  logic [DW-1:0] d   [0:QW];
  logic          ov  [0:QW];

  logic [MW-1:0] top_ext;
  logic [MW-1:0] den_ext;

  assign top_ext = MW'(num[NW-1:QW]);
  assign den_ext = MW'(den);

  // quotient needs more than QW bits when the upper part already reaches den
  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]  <= top_ext >= den_ext;
      rem[0] <= top_ext[DW-1:0];
      low[0] <= num[QW-1:0];
      q[0]   <= '0;
      d[0]   <= den;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] sh;
    logic        ge;
    logic [DW:0] diff;

    assign sh   = {rem[k-1], low[k-1][QW-1]};
    assign diff = sh - {1'b0, d[k-1]};
    assign ge   = sh >= {1'b0, d[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        low[k] <= {low[k-1][QW-2:0], 1'b0};
        q[k]   <= {q[k-1][QW-2:0], ge};
        d[k]   <= d[k-1];
        ov[k]  <= ov[k-1];
      end
    end
  end

  assign quo = q[QW];
  assign ovf = ov[QW];

endmodule

/* rtl/radar_measurement_jacobian.sv */
// Radar measurement Jacobian: deep pipeline from state vector to six entries.
// Throughput: one beat per cycle unless stalled; the bit-per-stage square root
// (DATA_WIDTH stages) and six bit-per-stage dividers (DATA_WIDTH+1 stages) set
// the depth. The whole pipe advances together and holds on a stalled output beat.
// Reset (rst, synchronous): all valid bits clear, guard returns to 429497.
`timescale 1ns / 1ps
module radar_measurement_jacobian #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  // fields from bit 0 up: pos_x, pos_y, vel_x, vel_y
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // fields from bit 0 up: d_range_d_px, d_range_d_py, d_bearing_d_px,
  // d_bearing_d_py, d_rate_d_px, d_rate_d_py
  output logic [((6*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // fields from bit 0 up: near_zero_error
  output logic [0:0]                        m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_we,
  input  logic [rmj_pkg::GUARD_WIDTH-1:0]   cfg_wdata
);
  import rmj_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int W2    = 2 * W;
  localparam int W3    = 3 * W;
  localparam int OUT_W = ((6 * W + 7) / 8) * 8;
  localparam int CW    = (W2 > GUARD_WIDTH) ? W2 : GUARD_WIDTH;
  // sqrt sideband: err, sx, sy, cneg, ax, ay, cmag, s
  localparam int SB1   = 4 + 2 * W + 2 * W2;
  // divider sideband: err and the six result signs
  localparam int SB2   = 7;

  // ---------------------------------------------------------------- control
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [GUARD_WIDTH-1:0] guard;
  always_ff @(posedge clk) begin
    if (rst) begin
      guard <= GUARD_RESET;
    end else if (cfg_we) begin
      guard <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- stage A
  // magnitudes, squares and the two cross products
  logic signed [W-1:0] px, py, vx, vy;
  logic        [W-1:0] ax, ay;
  assign px = s_tdata[0*W +: W];
  assign py = s_tdata[1*W +: W];
  assign vx = s_tdata[2*W +: W];
  assign vy = s_tdata[3*W +: W];
  assign ax = px[W-1] ? (~px + 1'b1) : px;
  assign ay = py[W-1] ? (~py + 1'b1) : py;

  logic                 a_v;
  logic [W2-1:0]        a_axx, a_ayy;
  logic signed [W2-1:0] a_p1, a_p2;
  logic [W-1:0]         a_ax, a_ay;
  logic                 a_sx, a_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_axx <= W2'(ax) * W2'(ax);
      a_ayy <= W2'(ay) * W2'(ay);
      a_p1  <= W2'(vx) * W2'(py);
      a_p2  <= W2'(vy) * W2'(px);
      a_ax  <= ax;
      a_ay  <= ay;
      a_sx  <= px[W-1];
      a_sy  <= py[W-1];
    end
  end

  // ---------------------------------------------------------------- stage B
  // squared range, cross term c = vx*py - vy*px, guard check
  logic signed [W2:0] cdiff;
  logic [W2-1:0]      ssum;
  assign cdiff = {a_p1[W2-1], a_p1} - {a_p2[W2-1], a_p2};
  assign ssum  = a_axx + a_ayy;

  logic          b_v;
  logic [W2-1:0] b_s, b_cmag;
  logic [W-1:0]  b_ax, b_ay;
  logic          b_sx, b_sy, b_cneg, b_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_s    <= ssum;
      b_cneg <= cdiff[W2];
      b_cmag <= cdiff[W2] ? W2'(-cdiff) : cdiff[W2-1:0];
      b_err  <= (CW'(ssum) < CW'(guard)) || (ssum == '0);
      b_ax   <= a_ax;
      b_ay   <= a_ay;
      b_sx   <= a_sx;
      b_sy   <= a_sy;
    end
  end

  // ---------------------------------------------------------------- range
  logic           q_v;
  logic [W-1:0]   q_r;
  logic [SB1-1:0] q_sb;

  rmj_isqrt #(
    .RW  (W),
    .SBW (SB1)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_v),
    .s         (b_s),
    .in_sb     ({b_err, b_sx, b_sy, b_cneg, b_ax, b_ay, b_cmag, b_s}),
    .out_valid (q_v),
    .root      (q_r),
    .out_sb    (q_sb)
  );

  logic          q_err, q_sx, q_sy, q_cneg;
  logic [W-1:0]  q_ax, q_ay;
  logic [W2-1:0] q_cmag, q_s;
  assign {q_err, q_sx, q_sy, q_cneg, q_ax, q_ay, q_cmag, q_s} = q_sb;

  // ---------------------------------------------------------------- stage C
  // half-width partial products for S*r and |p|*|c|
  logic          c_v;
  logic [W2-1:0] c_srlo, c_srhi, c_nylo, c_nyhi, c_nxlo, c_nxhi;
  logic [W-1:0]  c_ax, c_ay, c_r;
  logic [W2-1:0] c_s;
  logic          c_sx, c_sy, c_cneg, c_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_srlo <= W2'(q_s[W-1:0]) * W2'(q_r);
      c_srhi <= W2'(q_s[W2-1:W]) * W2'(q_r);
      c_nylo <= W2'(q_ay) * W2'(q_cmag[W-1:0]);
      c_nyhi <= W2'(q_ay) * W2'(q_cmag[W2-1:W]);
      c_nxlo <= W2'(q_ax) * W2'(q_cmag[W-1:0]);
      c_nxhi <= W2'(q_ax) * W2'(q_cmag[W2-1:W]);
      c_ax   <= q_ax;
      c_ay   <= q_ay;
      c_r    <= q_r;
      c_s    <= q_s;
      c_sx   <= q_sx;
      c_sy   <= q_sy;
      c_cneg <= q_cneg;
      c_err  <= q_err;
    end
  end

  // ---------------------------------------------------------------- stage D
  logic          d_v;
  logic [W3-1:0] d_sr, d_ny, d_nx;
  logic [W-1:0]  d_ax, d_ay, d_r;
  logic [W2-1:0] d_s;
  logic [SB2-1:0] d_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_sr <= {c_srhi, {W{1'b0}}} + W3'(c_srlo);
      d_ny <= {c_nyhi, {W{1'b0}}} + W3'(c_nylo);
      d_nx <= {c_nxhi, {W{1'b0}}} + W3'(c_nxlo);
      d_ax <= c_ax;
      d_ay <= c_ay;
      d_r  <= c_r;
      d_s  <= c_s;
      // result signs, entry 0 in bit 0; bit 6 is the guard error
      d_sb <= {c_err,
               c_sx == c_cneg,
               c_sy != c_cneg,
               c_sx,
               !c_sy,
               c_sy,
               c_sx};
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [W-1:0] qt [0:5];
  logic         ov [0:5];

  rmj_div #(.NW(W + F), .DW(W), .QW(W)) u_div_rx (
    .clk (clk), .en (en), .num ({d_ax, {F{1'b0}}}), .den (d_r),
    .quo (qt[0]), .ovf (ov[0])
  );
  rmj_div #(.NW(W + F), .DW(W), .QW(W)) u_div_ry (
    .clk (clk), .en (en), .num ({d_ay, {F{1'b0}}}), .den (d_r),
    .quo (qt[1]), .ovf (ov[1])
  );
  rmj_div #(.NW(W + 2 * F), .DW(W2), .QW(W)) u_div_bx (
    .clk (clk), .en (en), .num ({d_ay, {(2 * F){1'b0}}}), .den (d_s),
    .quo (qt[2]), .ovf (ov[2])
  );
  rmj_div #(.NW(W + 2 * F), .DW(W2), .QW(W)) u_div_by (
    .clk (clk), .en (en), .num ({d_ax, {(2 * F){1'b0}}}), .den (d_s),
    .quo (qt[3]), .ovf (ov[3])
  );
  rmj_div #(.NW(W3 + F), .DW(W3), .QW(W)) u_div_vx (
    .clk (clk), .en (en), .num ({d_ny, {F{1'b0}}}), .den (d_sr),
    .quo (qt[4]), .ovf (ov[4])
  );
  rmj_div #(.NW(W3 + F), .DW(W3), .QW(W)) u_div_vy (
    .clk (clk), .en (en), .num ({d_nx, {F{1'b0}}}), .den (d_sr),
    .quo (qt[5]), .ovf (ov[5])
  );

  logic           e_v;
  logic [SB2-1:0] e_sb;

  rmj_delay #(
    .WIDTH (SB2),
    .DEPTH (W + 1)
  ) u_sb_delay (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_v),
    .in_data   (d_sb),
    .out_valid (e_v),
    .out_data  (e_sb)
  );

  // ---------------------------------------------------------------- output
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  // signed saturation of an unsigned quotient magnitude
  function automatic logic [W-1:0] sat_sign(input logic [W-1:0] q,
                                            input logic ovf, input logic neg);
    logic [W-1:0] res;
    if (neg) begin
      res = (ovf || q > MIN_NEG) ? MIN_NEG : (~q + 1'b1);
    end else begin
      res = (ovf || q[W-1]) ? MAX_POS : q;
    end
    return res;
  endfunction

  logic [W-1:0] res [0:5];
  for (genvar j = 0; j < 6; j++) begin : g_res
    assign res[j] = e_sb[SB2-1] ? '0 : sat_sign(qt[j], ov[j], e_sb[j]);
  end

  logic [6*W-1:0] o_data;
  logic           o_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_data <= {res[5], res[4], res[3], res[2], res[1], res[0]};
      o_err  <= e_sb[SB2-1];
    end
  end

  assign m_tdata = OUT_W'(o_data);
  assign m_tuser = o_err;

  // ---------------------------------------------------------------- checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (o_data == '0))
    else $error("error beat carries nonzero entries");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output beat stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
